// ===== design/hspm_pkg.sv =====
// Shared types and constants of the hashed sparse page memory.
// No dependencies; imported by hspm_hash and the core module.
`timescale 1ns / 1ps
`default_nettype none

package hspm_pkg;

  // Multiply-xor hash constants
  localparam logic [31:0] HashMul   = 32'h045d9f3b;
  localparam int          HashShift = 16;

  // Access operation codes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SWAP  = 2'd2
  } op_e;

  // Access sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_CHECK,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// ===== design/hspm_hash.sv =====
// Two-stage multiply-xor hash of a page base address.
// Depends on hspm_pkg for the hash multiplier and shift.
`timescale 1ns / 1ps
`default_nettype none

module hspm_hash import hspm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] key_i,
  output logic             valid_o,
  output logic [31:0]      hash_o
);

  logic        v1_q, v2_q;
  logic [31:0] mix0, mix1;
  logic [31:0] prod1_d, prod2_d;
  logic [31:0] prod1_q, prod2_q;

  // Fold and multiply, one multiplication per stage
  assign mix0    = key_i ^ (key_i >> HashShift);
  assign prod1_d = mix0 * HashMul;
  assign mix1    = prod1_q ^ (prod1_q >> HashShift);
  assign prod2_d = mix1 * HashMul;

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  // Hold the products
  always_ff @(posedge clk_i) begin
    prod1_q <= prod1_d;
    prod2_q <= prod2_d;
  end

  // Final fold
  assign hash_o  = prod2_q ^ (prod2_q >> HashShift);
  assign valid_o = v2_q;

endmodule

`default_nettype wire

// ===== design/hspm_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies; used for the bucket table and the frame store.
`timescale 1ns / 1ps
`default_nettype none

module hspm_ram #(
  parameter int AddrW = 6,
  parameter int DataW = 32
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [2**AddrW];
  logic [DataW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/hashed_sparse_page_memory_core.sv =====
// Hashed sparse page memory: read, write and swap over a 32-bit word space.
// An access passes through the hash, a bucket read and check per probe, and the finish
// step, where the result word is registered; a new access is taken only in idle, once
// the previous result has been loaded into the output register.
// Reset: a clearing pass over the BUCKETS*PAGE_WORDS words (65536 by default) zeroes the
// frame store and the bucket table, with page 0 in its bucket; no input is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module hashed_sparse_page_memory_core import hspm_pkg::*; #(
  parameter int BUCKETS    = 64,
  parameter int PAGE_WORDS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      read_data_o,
  output logic             status_o,
  output logic             page_created_o
);

  localparam int BucketW = $clog2(BUCKETS);
  localparam int OffW    = $clog2(PAGE_WORDS);
  localparam int PnW     = 32 - OffW;
  localparam int FrameW  = BucketW + OffW;

  state_e state_q, state_d;

  logic [FrameW-1:0]  clr_q;
  logic [1:0]         op_q;
  logic [OffW-1:0]    off_q;
  logic [PnW-1:0]     pn_q;
  logic [31:0]        wdata_q;
  logic [BucketW-1:0] idx_q, probes_q;
  logic               full_q, created_q;
  logic               out_valid_q, out_status_q, out_created_q;
  logic [31:0]        out_rdata_q;

  logic               in_fire, out_free, out_load;
  logic               hash_valid;
  logic [31:0]        hash;
  logic [BucketW-1:0] hash_idx;
  logic               last_probe, clr_done;

  logic               bkt_we, bkt_re;
  logic [BucketW-1:0] bkt_waddr, bkt_raddr;
  logic [PnW:0]       bkt_wdata, bkt_rdata;
  logic               bkt_rvalid, bkt_hit;

  logic               frm_we, frm_re;
  logic [FrameW-1:0]  frm_waddr;
  logic [31:0]        frm_wdata, frm_rdata;

  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign hash_idx   = hash[BucketW-1:0];
  assign last_probe = (probes_q == BucketW'(BUCKETS - 1));
  assign clr_done   = (clr_q == FrameW'(BUCKETS * PAGE_WORDS - 1));
  assign bkt_rvalid = bkt_rdata[PnW];
  assign bkt_hit    = bkt_rvalid && (bkt_rdata[PnW-1:0] == pn_q);

  // Hash the page base of the incoming word
  hspm_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .key_i   ({address_i[31:OffW], OffW'(0)}),
    .valid_o (hash_valid),
    .hash_o  (hash)
  );

  // Bucket table: valid bit over page number
  hspm_ram #(
    .AddrW (BucketW),
    .DataW (PnW + 1)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (bkt_wdata),
    .re_i    (bkt_re),
    .raddr_i (bkt_raddr),
    .rdata_o (bkt_rdata)
  );

  // Frame store: one page frame per bucket
  hspm_ram #(
    .AddrW (FrameW),
    .DataW (32)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frm_we),
    .waddr_i (frm_waddr),
    .wdata_i (frm_wdata),
    .re_i    (frm_re),
    .raddr_i ({idx_q, off_q}),
    .rdata_o (frm_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_HASH;
      end
      ST_HASH: begin
        if (hash_valid) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!bkt_rvalid || bkt_hit || last_probe) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Memory controls and handshake
  always_comb begin
    in_ready_o = 1'b0;
    bkt_re     = 1'b0;
    bkt_raddr  = idx_q + BucketW'(1);
    bkt_we     = 1'b0;
    bkt_waddr  = idx_q;
    bkt_wdata  = {1'b1, pn_q};
    frm_re     = 1'b0;
    frm_we     = 1'b0;
    frm_waddr  = {idx_q, off_q};
    frm_wdata  = wdata_q;
    out_load   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_q[BucketW-1:0];
        bkt_wdata = {(clr_q[BucketW-1:0] == '0), PnW'(0)};
        frm_we    = 1'b1;
        frm_waddr = clr_q;
        frm_wdata = '0;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_HASH: begin
        bkt_re    = hash_valid;
        bkt_raddr = hash_idx;
      end
      ST_CHECK: begin
        if (!bkt_rvalid) begin
          bkt_we = 1'b1;
          frm_re = 1'b1;
        end else if (bkt_hit) begin
          frm_re = 1'b1;
        end else begin
          bkt_re = !last_probe;
        end
      end
      ST_FINISH: begin
        out_load = out_free;
        frm_we   = out_free && !full_q && (op_q inside {OP_WRITE, OP_SWAP});
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Sequencer control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      probes_q    <= '0;
      full_q      <= 1'b0;
      created_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + FrameW'(1);
      end
      if (state_q == ST_HASH && hash_valid) begin
        idx_q     <= hash_idx;
        probes_q  <= '0;
        full_q    <= 1'b0;
        created_q <= 1'b0;
      end
      if (state_q == ST_CHECK) begin
        if (!bkt_rvalid) begin
          created_q <= 1'b1;
        end else if (!bkt_hit) begin
          if (last_probe) begin
            full_q <= 1'b1;
          end else begin
            idx_q    <= idx_q + BucketW'(1);
            probes_q <= probes_q + BucketW'(1);
          end
        end
      end
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= operation_i;
      off_q   <= address_i[OffW-1:0];
      pn_q    <= address_i[31:OffW];
      wdata_q <= write_data_i;
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rdata_q   <= (full_q || op_q == OP_WRITE) ? 32'd0 : frm_rdata;
      out_status_q  <= full_q;
      out_created_q <= created_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_rdata_q;
  assign status_o       = out_status_q;
  assign page_created_o = out_created_q;

`ifndef SYNTHESIS
  // A refused access returns zero and creates no page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> read_data_o == 32'd0 && !page_created_o)
    else $error("refused access returned data or a page");

  // Allocation only claims an empty bucket
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bkt_we && state_q == ST_CHECK |-> !bkt_rvalid)
    else $error("bucket overwritten while occupied");

  // No hash is in flight while new input is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !hash_valid)
    else $error("hash result outstanding in idle");

  // A result is only loaded from the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_FINISH)
    else $error("result loaded outside finish step");
`endif

endmodule

`default_nettype wire
